// File: rtl/core/fbc_pkg.sv
// shared constants, command codes and types for the frustum box cull block
package fbc_pkg;
	localparam int PLANE_COUNT   = 6;
	localparam int FRAC_BITS_DEF = 16;
	localparam int COEF_W        = 32;
	localparam logic [30:0] MARGIN_RESET = 31'd327680;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_BUILD = 2'd1,
		CMD_TEST  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic {
		REG_MARGIN = 1'b0,
		REG_NORM   = 1'b1
	} reg_idx_t;

	typedef enum logic [8:0] {
		ST_IDLE    = 9'b000000001,
		ST_BLD_W   = 9'b000000010,
		ST_BLD_R   = 9'b000000100,
		ST_NRM_SQ  = 9'b000001000,
		ST_NRM_RT  = 9'b000010000,
		ST_NRM_DV  = 9'b000100000,
		ST_BOX     = 9'b001000000,
		ST_BOX_CMP = 9'b010000000,
		ST_DONE    = 9'b100000000
	} state_t;

	typedef struct packed {
		logic start;
		logic done;
	} unit_ctl_t;
endpackage

// File: rtl/core/fbc_sqrt.sv
// iterative integer square root, two radicand bits per cycle
module fbc_sqrt (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [63:0]       radicand,
	output logic              done,
	output logic [31:0]       root
);
	import fbc_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [63:0] rad_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [33:0] rem_t;
	logic [33:0] trial;

	assign rem_t = {rem_q[31:0], rad_q[63:62]};
	assign trial = {root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[61:0], 2'b00};
			if (rem_t >= trial) begin
				rem_q  <= rem_t - trial;
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q  <= rem_t;
				root_q <= {root_q[30:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && cnt_q != 5'd31 |=> !done_q)
		else $error("sqrt finished early");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q || $past(start, 2))
		else $error("sqrt done held");
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q || $past(start))
		else $error("sqrt done while busy");
endmodule

// File: rtl/core/fbc_div.sv
// iterative restoring divider, one quotient bit per cycle
module fbc_div #(
	parameter int NUM_W = 48
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] numer,
	input  logic [31:0]      denom,
	output logic             done,
	output logic [NUM_W-1:0] quot
);
	import fbc_pkg::*;

	localparam int CNT_W = $clog2(NUM_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [31:0]      den_q;
	logic [32:0]      rem_q;
	logic [32:0]      rem_t;

	assign rem_t = {rem_q[31:0], num_q[NUM_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= numer;
			den_q <= denom;
			rem_q <= '0;
		end else if (busy_q) begin
			if (rem_t >= {1'b0, den_q}) begin
				rem_q <= rem_t - {1'b0, den_q};
				num_q <= {num_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_t;
				num_q <= {num_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = num_q;

	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && cnt_q != CNT_W'(NUM_W - 1) && !start |=> busy_q)
		else $error("divider dropped busy early");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without work");
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !$past(start) |-> rem_q < {1'b0, den_q} || den_q == 32'd0)
		else $error("divider remainder out of range");
endmodule

// File: rtl/core/frustum_box_cull.sv
// frustum box cull top level: sequencer, matrix and plane stores, shared multiplier
// Each transfer is taken only while the block is idle, and every command but CMD_NONE
// then passes through the done state, which waits for a free output slot, and back to
// idle before the next transfer is taken. A matrix load writes its element and goes
// straight to the done state. A box test tries corners per plane (one shared 32x32
// multiplier, three products per corner, early exit per plane). A plane build forms
// each plane coefficient and then, with normalize on, per plane a square sum, a square
// root and four divides (a plane with a zero-length normal skips its divides). A finished
// result waits in the output register while the next command is already taken.
module frustum_box_cull #(
	parameter int FRAC_BITS = fbc_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  cmd,
	input  logic [3:0]  elem_index,
	input  logic signed [31:0] elem_value,
	input  logic signed [31:0] box_x_min,
	input  logic signed [31:0] box_y_min,
	input  logic signed [31:0] box_z_min,
	input  logic signed [31:0] box_x_max,
	input  logic signed [31:0] box_y_max,
	input  logic signed [31:0] box_z_max,
	output logic        res_valid,
	input  logic        res_stall,
	output logic        visible,
	output logic        plane_error,
	output logic [1:0]  done_cmd,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	import fbc_pkg::*;

	localparam int NUM_W = COEF_W + FRAC_BITS;
	localparam logic [2:0] LAST_PLANE = 3'(PLANE_COUNT - 1);

	state_t state_q;
	logic [1:0]  cmd_q;
	logic [2:0]  plane_q;
	logic [1:0]  coef_q;
	logic [2:0]  step_q;
	logic [2:0]  corner_q;
	logic signed [64:0] acc_q;
	logic signed [63:0] prod_q;
	logic signed [31:0] w_q;
	logic        err_q;
	logic        vis_q;
	logic [31:0] len_q;
	logic        neg_q;
	logic signed [31:0] lo_q [3];
	logic signed [31:0] hi_q [3];
	logic [30:0] margin_q;
	logic        norm_en_q;
	logic signed [31:0] matrix_q [16];
	logic signed [31:0] plane_q_mem [PLANE_COUNT*4];

	logic        out_valid_q;
	logic        out_vis_q;
	logic        out_err_q;
	logic [1:0]  out_cmd_q;

	logic        accept;
	logic        slot_free;
	logic [4:0]  prd_idx;
	logic signed [31:0] prd;
	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [63:0] prod_sh;
	logic signed [32:0] bsum;
	logic signed [31:0] bsat;
	logic        neg_row;
	logic [1:0]  brow;
	logic signed [64:0] lim;
	unit_ctl_t   sq_ctl;
	unit_ctl_t   dv_ctl;
	logic [31:0] sq_root;
	logic [NUM_W-1:0] dv_num;
	logic [NUM_W-1:0] dv_quot;
	logic [31:0] pmag;
	logic signed [31:0] qsat;

	assign accept     = item_valid && !item_stall;
	assign item_stall = (state_q != ST_IDLE);
	assign slot_free  = !out_valid_q || !res_stall;
	assign cfg_ready  = 1'b1;

	always_comb begin
		prd_idx = {plane_q, coef_q};
		case (state_q)
			ST_BOX: begin
				case (step_q)
					3'd0:    prd_idx = {plane_q, 2'd3};
					3'd1:    prd_idx = {plane_q, 2'd0};
					3'd2:    prd_idx = {plane_q, 2'd1};
					default: prd_idx = {plane_q, 2'd2};
				endcase
			end
			ST_NRM_SQ: prd_idx = {plane_q, step_q[1:0]};
			default:   prd_idx = {plane_q, coef_q};
		endcase
	end
	assign prd = plane_q_mem[prd_idx];

	always_comb begin
		mul_a = prd;
		mul_b = prd;
		if (state_q == ST_BOX) begin
			case (step_q)
				3'd1:    mul_b = corner_q[2] ? hi_q[0] : lo_q[0];
				3'd2:    mul_b = corner_q[1] ? hi_q[1] : lo_q[1];
				default: mul_b = corner_q[0] ? hi_q[2] : lo_q[2];
			endcase
		end
	end

	assign prod_sh = prod_q >>> FRAC_BITS;
	assign brow    = plane_q[2:1];
	assign neg_row = (plane_q == 3'd1) || (plane_q == 3'd2) || (plane_q == 3'd5);
	assign bsum    = neg_row ? ({w_q[31], w_q} - {matrix_q[{coef_q, brow}][31],
			matrix_q[{coef_q, brow}]})
		: ({w_q[31], w_q} + {matrix_q[{coef_q, brow}][31], matrix_q[{coef_q, brow}]});
	assign bsat    = (bsum[32] != bsum[31]) ? (bsum[32] ? 32'sh80000000 : 32'sh7fffffff)
		: bsum[31:0];
	assign lim     = -$signed({34'd0, margin_q});
	assign pmag    = prd[31] ? (32'd0 - prd) : prd;
	assign dv_num  = {pmag, FRAC_BITS'(0)};

	always_comb begin
		if (neg_q) begin
			if (dv_quot > NUM_W'(33'h080000000)) qsat = 32'sh80000000;
			else qsat = 32'(NUM_W'(0) - dv_quot);
		end else begin
			if (dv_quot > NUM_W'(32'h7fffffff)) qsat = 32'sh7fffffff;
			else qsat = 32'(dv_quot);
		end
	end

	always_comb begin
		sq_ctl.start = (state_q == ST_NRM_SQ) && (step_q == 3'd4);
		dv_ctl.start = (state_q == ST_NRM_RT) && sq_ctl.done && (sq_root != 32'd0);
	end

	fbc_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_ctl.start),
		.radicand (acc_q[63:0]),
		.done     (sq_ctl.done),
		.root     (sq_root)
	);

	fbc_div #(.NUM_W(NUM_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dv_ctl.start || ((state_q == ST_NRM_DV) && dv_ctl.done && coef_q != 2'd3)),
		.numer  ((state_q == ST_NRM_DV) ? {(plane_q_mem[{plane_q, coef_q + 2'd1}][31]
				? (32'd0 - plane_q_mem[{plane_q, coef_q + 2'd1}])
				: plane_q_mem[{plane_q, coef_q + 2'd1}]), FRAC_BITS'(0)} : dv_num),
		.denom  ((state_q == ST_NRM_DV) ? len_q : sq_root),
		.done   (dv_ctl.done),
		.quot   (dv_quot)
	);

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cmd_q     <= CMD_NONE;
			plane_q   <= '0;
			coef_q    <= '0;
			step_q    <= '0;
			corner_q  <= '0;
			err_q     <= 1'b0;
			vis_q     <= 1'b0;
			margin_q  <= MARGIN_RESET;
			norm_en_q <= 1'b1;
			for (int i = 0; i < 16; i++) matrix_q[i] <= '0;
			for (int i = 0; i < PLANE_COUNT*4; i++) plane_q_mem[i] <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_MARGIN: margin_q  <= cfg_data[30:0];
					REG_NORM:   norm_en_q <= cfg_data[0];
					default:    ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cmd_q    <= cmd;
						err_q    <= 1'b0;
						vis_q    <= 1'b0;
						plane_q  <= '0;
						coef_q   <= '0;
						step_q   <= '0;
						corner_q <= '0;
						case (cmd_t'(cmd))
							CMD_LOAD: begin
								matrix_q[elem_index] <= elem_value;
								state_q <= ST_DONE;
							end
							CMD_BUILD: state_q <= ST_BLD_W;
							CMD_TEST:  state_q <= ST_BOX;
							default:   state_q <= ST_IDLE;
						endcase
					end
				end
				ST_BLD_W: begin
					w_q     <= matrix_q[{coef_q, 2'd3}];
					state_q <= ST_BLD_R;
				end
				ST_BLD_R: begin
					plane_q_mem[{plane_q, coef_q}] <= bsat;
					coef_q  <= coef_q + 2'd1;
					state_q <= ST_BLD_W;
					if (coef_q == 2'd3) begin
						plane_q <= plane_q + 3'd1;
						if (plane_q == LAST_PLANE) begin
							plane_q <= '0;
							step_q  <= '0;
							state_q <= norm_en_q ? ST_NRM_SQ : ST_DONE;
						end
					end
				end
				ST_NRM_SQ: begin
					step_q <= step_q + 3'd1;
					case (step_q)
						3'd0:    acc_q <= '0;
						3'd4:    state_q <= ST_NRM_RT;
						default: acc_q <= acc_q + {1'b0, prod_q};
					endcase
				end
				ST_NRM_RT: begin
					if (sq_ctl.done) begin
						len_q  <= sq_root;
						coef_q <= '0;
						neg_q  <= prd[31];
						if (sq_root == 32'd0) begin
							err_q   <= 1'b1;
							plane_q <= plane_q + 3'd1;
							step_q  <= '0;
							state_q <= (plane_q == LAST_PLANE) ? ST_DONE : ST_NRM_SQ;
						end else begin
							state_q <= ST_NRM_DV;
						end
					end
				end
				ST_NRM_DV: begin
					if (dv_ctl.done) begin
						plane_q_mem[{plane_q, coef_q}] <= qsat;
						coef_q <= coef_q + 2'd1;
						neg_q  <= plane_q_mem[{plane_q, coef_q + 2'd1}][31];
						if (coef_q == 2'd3) begin
							plane_q <= plane_q + 3'd1;
							step_q  <= '0;
							state_q <= (plane_q == LAST_PLANE) ? ST_DONE : ST_NRM_SQ;
						end
					end
				end
				ST_BOX: begin
					step_q <= step_q + 3'd1;
					case (step_q)
						3'd0:    acc_q <= {{33{prd[31]}}, prd};
						3'd1:    ;
						default: acc_q <= acc_q + {prod_sh[63], prod_sh};
					endcase
					if (step_q == 3'd4) state_q <= ST_BOX_CMP;
				end
				ST_BOX_CMP: begin
					step_q  <= '0;
					state_q <= ST_BOX;
					if (acc_q >= lim) begin
						corner_q <= '0;
						plane_q  <= plane_q + 3'd1;
						if (plane_q == LAST_PLANE) begin
							vis_q   <= 1'b1;
							state_q <= ST_DONE;
						end
					end else begin
						corner_q <= corner_q + 3'd1;
						if (corner_q == 3'd7) state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (slot_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && cmd_t'(cmd) == CMD_TEST) begin
			lo_q[0] <= box_x_min;
			lo_q[1] <= box_y_min;
			lo_q[2] <= box_z_min;
			hi_q[0] <= box_x_max;
			hi_q[1] <= box_y_max;
			hi_q[2] <= box_z_max;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && slot_free) begin
			out_vis_q <= vis_q;
			out_err_q <= err_q;
			out_cmd_q <= cmd_q;
		end
	end

	assign res_valid   = out_valid_q;
	assign visible     = out_vis_q;
	assign plane_error = out_err_q;
	assign done_cmd    = out_cmd_q;

	a_res_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(state_q == ST_DONE))
		else $error("result without finished command");
	a_vis_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && visible |-> done_cmd == CMD_TEST)
		else $error("visible on non-test command");
	a_err_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && plane_error |-> done_cmd == CMD_BUILD)
		else $error("plane error on non-build command");
	a_sqrt_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sq_ctl.start |=> state_q == ST_NRM_RT)
		else $error("sequencer left sqrt wait");
endmodule
